@@ sv/fst_pkg.sv @@
// shared constants, codes and the chain item type of the flow statistics table
`timescale 1ns / 1ps
package fst_pkg;

   localparam int FlowEntries = 16;
   localparam int NodeIdBits  = 8;

   localparam int ActionBits  = 2;
   localparam int NodeBits    = 8;
   localparam int DelayBits   = 16;
   localparam int StatusBits  = 3;
   localparam int CountBits   = 32;
   localparam int TotalBits   = 48;

   typedef enum logic [ActionBits-1:0] {
      ACT_ADD     = 2'd0,
      ACT_CREATED = 2'd1,
      ACT_ARRIVED = 2'd2
   } action_type;

   typedef enum logic [StatusBits-1:0] {
      ST_UPDATED = 3'd0,
      ST_UNKNOWN = 3'd1,
      ST_ADDED   = 3'd2,
      ST_PRESENT = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   // one event as it walks along the row of cells
   typedef struct packed {
      logic                  valid;
      logic [ActionBits-1:0] action;
      logic [NodeIdBits-1:0] src_node;
      logic [NodeIdBits-1:0] dest_node;
      logic [DelayBits-1:0]  delay;
      logic                  done;
      status_type            status;
      logic [CountBits-1:0]  attempted_count;
      logic [CountBits-1:0]  arrived_count;
      logic [TotalBits-1:0]  delay_total;
   } item_type;

endpackage

@@ sv/fst_req_if.sv @@
// event channel of the flow statistics table
`timescale 1ns / 1ps
interface fst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  src_node;
   logic [7:0]  dest_node;
   logic [15:0] delay;

   modport source (output valid, action, src_node, dest_node, delay, input ready);
   modport sink (input valid, action, src_node, dest_node, delay, output ready);
endinterface

@@ sv/fst_rsp_if.sv @@
// result channel of the flow statistics table
`timescale 1ns / 1ps
interface fst_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] attempted_count;
   logic [31:0] arrived_count;
   logic [47:0] delay_total;

   modport source (output valid, status, attempted_count, arrived_count, delay_total,
                   input ready);
   modport sink (input valid, status, attempted_count, arrived_count, delay_total,
                 output ready);
endinterface

@@ sv/fst_cell.sv @@
// one table entry plus the stage register that hands the item to the next entry
`timescale 1ns / 1ps
module fst_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  fst_pkg::item_type up_item,
   output fst_pkg::item_type down_item
);
   import fst_pkg::*;

   logic                  entry_valid_ff, entry_valid_in;
   logic [NodeIdBits-1:0] entry_src_ff, entry_src_in;
   logic [NodeIdBits-1:0] entry_dst_ff, entry_dst_in;
   logic [CountBits-1:0]  entry_att_ff, entry_att_in;
   logic [CountBits-1:0]  entry_arr_ff, entry_arr_in;
   logic [TotalBits-1:0]  entry_dly_ff, entry_dly_in;
   item_type              item_ff, item_in;
   logic                  key_match;
   logic [CountBits-1:0]  att_sat, arr_sat;
   logic [TotalBits:0]    dly_sum;
   logic [TotalBits-1:0]  dly_sat;

   assign key_match = entry_valid_ff && (entry_src_ff == up_item.src_node)
                      && (entry_dst_ff == up_item.dest_node);

   assign att_sat = (entry_att_ff == '1) ? entry_att_ff : entry_att_ff + 1'b1;
   assign arr_sat = (entry_arr_ff == '1) ? entry_arr_ff : entry_arr_ff + 1'b1;
   assign dly_sum = {1'b0, entry_dly_ff} + (TotalBits + 1)'(up_item.delay);
   assign dly_sat = dly_sum[TotalBits] ? '1 : dly_sum[TotalBits-1:0];

   always_comb begin
      entry_valid_in = entry_valid_ff;
      entry_src_in   = entry_src_ff;
      entry_dst_in   = entry_dst_ff;
      entry_att_in   = entry_att_ff;
      entry_arr_in   = entry_arr_ff;
      entry_dly_in   = entry_dly_ff;
      item_in        = up_item;
      if (up_item.valid && !up_item.done) begin
         if (key_match) begin
            unique case (up_item.action)
               ACT_ADD: begin
                  item_in.done            = 1'b1;
                  item_in.status          = ST_PRESENT;
                  item_in.attempted_count = entry_att_ff;
                  item_in.arrived_count   = entry_arr_ff;
                  item_in.delay_total     = entry_dly_ff;
               end
               ACT_CREATED: begin
                  entry_att_in            = att_sat;
                  item_in.done            = 1'b1;
                  item_in.status          = ST_UPDATED;
                  item_in.attempted_count = att_sat;
                  item_in.arrived_count   = entry_arr_ff;
                  item_in.delay_total     = entry_dly_ff;
               end
               ACT_ARRIVED: begin
                  entry_arr_in            = arr_sat;
                  entry_dly_in            = dly_sat;
                  item_in.done            = 1'b1;
                  item_in.status          = ST_UPDATED;
                  item_in.attempted_count = entry_att_ff;
                  item_in.arrived_count   = arr_sat;
                  item_in.delay_total     = dly_sat;
               end
               default: begin
                  // unused action code passes through and ends as unknown
               end
            endcase
         end else if (!entry_valid_ff && up_item.action == ACT_ADD) begin
            // entries fill from the low end, so no match can lie further on
            entry_valid_in          = 1'b1;
            entry_src_in            = up_item.src_node;
            entry_dst_in            = up_item.dest_node;
            entry_att_in            = '0;
            entry_arr_in            = '0;
            entry_dly_in            = '0;
            item_in.done            = 1'b1;
            item_in.status          = ST_ADDED;
            item_in.attempted_count = '0;
            item_in.arrived_count   = '0;
            item_in.delay_total     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         item_ff.valid  <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= entry_valid_in;
         item_ff.valid  <= item_in.valid;
      end
      if (advance) begin
         entry_src_ff            <= entry_src_in;
         entry_dst_ff            <= entry_dst_in;
         entry_att_ff            <= entry_att_in;
         entry_arr_ff            <= entry_arr_in;
         entry_dly_ff            <= entry_dly_in;
         item_ff.action          <= item_in.action;
         item_ff.src_node        <= item_in.src_node;
         item_ff.dest_node       <= item_in.dest_node;
         item_ff.delay           <= item_in.delay;
         item_ff.done            <= item_in.done;
         item_ff.status          <= item_in.status;
         item_ff.attempted_count <= item_in.attempted_count;
         item_ff.arrived_count   <= item_in.arrived_count;
         item_ff.delay_total     <= item_in.delay_total;
      end
   end

   assign down_item = item_ff;

endmodule

@@ sv/flow_statistics_table_unit.sv @@
// Per-flow statistics table: top level with the row of entry cells.
// Usage: each event item on req_chan (action, src_node, dest_node, delay) adds a
// flow, counts a created packet or counts an arrival with its delay. Every item
// gives exactly one result on rsp_chan: a status and the flow's saturating
// counters as they stand after the event. Both channels use valid/ready.
// Path: an accepted item passes through an input register, one cell per entry,
// and the result register; a stall can hold it at any of them.
// Throughput: one item per cycle while results are taken, since items follow
// each other down the row of cells and each cell sees them in order.
// Stall: while a result waits untaken the row holds still; the input register
// still takes one more item if it is empty, then req_chan.ready drops.
// Reset: synchronous, active high; it empties the table and drops all items in
// flight. No clearing pass is needed, the table is usable the cycle after.
`timescale 1ns / 1ps
module flow_statistics_table_unit (
   input logic   clock,
   input logic   reset,
   fst_req_if.sink   req_chan,
   fst_rsp_if.source rsp_chan
);
   import fst_pkg::*;

   item_type              chain [FlowEntries+1];
   item_type              stage_ff, stage_in;
   item_type              last_item;
   logic                  advance;
   logic                  req_fire;
   logic                  rsp_valid_ff;
   logic [StatusBits-1:0] rsp_status_ff, rsp_status_in;
   logic [CountBits-1:0]  rsp_att_ff;
   logic [CountBits-1:0]  rsp_arr_ff;
   logic [TotalBits-1:0]  rsp_dly_ff;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance || !stage_ff.valid;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      stage_in                 = stage_ff;
      stage_in.action          = req_chan.action;
      stage_in.src_node        = req_chan.src_node[NodeIdBits-1:0];
      stage_in.dest_node       = req_chan.dest_node[NodeIdBits-1:0];
      stage_in.delay           = req_chan.delay;
      stage_in.done            = 1'b0;
      stage_in.status          = ST_UNKNOWN;
      stage_in.attempted_count = '0;
      stage_in.arrived_count   = '0;
      stage_in.delay_total     = '0;
      stage_in.valid           = req_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance || req_fire) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (req_fire) begin
         stage_ff.action          <= stage_in.action;
         stage_ff.src_node        <= stage_in.src_node;
         stage_ff.dest_node       <= stage_in.dest_node;
         stage_ff.delay           <= stage_in.delay;
         stage_ff.done            <= stage_in.done;
         stage_ff.status          <= stage_in.status;
         stage_ff.attempted_count <= stage_in.attempted_count;
         stage_ff.arrived_count   <= stage_in.arrived_count;
         stage_ff.delay_total     <= stage_in.delay_total;
      end
   end

   assign chain[0] = stage_ff;

   for (genvar k = 0; k < FlowEntries; k++) begin : g_cell
      fst_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .up_item   (chain[k]),
         .down_item (chain[k+1])
      );
   end

   assign last_item = chain[FlowEntries];

   // an item no cell took is either an add to a full table or unknown
   always_comb begin
      if (last_item.done) begin
         rsp_status_in = last_item.status;
      end else if (last_item.action == ACT_ADD) begin
         rsp_status_in = ST_FULL;
      end else begin
         rsp_status_in = ST_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last_item.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_att_ff    <= last_item.attempted_count;
         rsp_arr_ff    <= last_item.arrived_count;
         rsp_dly_ff    <= last_item.delay_total;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.attempted_count = rsp_att_ff;
   assign rsp_chan.arrived_count   = rsp_arr_ff;
   assign rsp_chan.delay_total     = rsp_dly_ff;

endmodule

@@ sv/fst_checker.sv @@
// port-level checks of the flow statistics table and their bind to the top level
`timescale 1ns / 1ps
module fst_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  status,
   input logic [31:0] attempted_count,
   input logic [31:0] arrived_count,
   input logic [47:0] delay_total
);
   import fst_pkg::*;

   logic counters_zero;

   assign counters_zero = (attempted_count == '0) && (arrived_count == '0)
                          && (delay_total == '0);

   // a result held back by the receiver stays valid, with status and delay total unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
                                  && $stable(delay_total))
      else $error("result changed while stalled");

   // reset drops any result shown on the port
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status == ST_UPDATED || status == ST_UNKNOWN || status == ST_ADDED
                    || status == ST_PRESENT || status == ST_FULL)
      else $error("status code out of range");

   // no entry behind the result means zero counters, and so does a fresh entry
   a_zero_counters: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_UNKNOWN || status == ST_FULL || status == ST_ADDED)
      |-> counters_zero)
      else $error("counters not zero for missing or new flow");

endmodule

bind flow_statistics_table_unit fst_checker u_fst_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .status          (rsp_chan.status),
   .attempted_count (rsp_chan.attempted_count),
   .arrived_count   (rsp_chan.arrived_count),
   .delay_total     (rsp_chan.delay_total)
);

@@ verif/flow_statistics_table_unit_tb.sv @@
// self-checking testbench of the flow statistics table: directed and random events, scored
`timescale 1ns / 1ps
module flow_statistics_table_unit_tb;
   import fst_pkg::*;

   localparam logic [ActionBits-1:0] ACT_UNUSED = 2'd3;
   localparam int RandomEvents = 800;
   localparam int DrainCycles  = 40;
   localparam int CycleLimit   = 200000;
   localparam int PoolLimit    = 20;

   typedef struct packed {
      logic [ActionBits-1:0] action;
      logic [NodeBits-1:0]   src_node;
      logic [NodeBits-1:0]   dest_node;
      logic [DelayBits-1:0]  delay;
   } flow_event_type;

   typedef struct packed {
      status_type           status;
      logic [CountBits-1:0] attempted_count;
      logic [CountBits-1:0] arrived_count;
      logic [TotalBits-1:0] delay_total;
   } flow_result_type;

   logic clock;
   logic reset;

   fst_req_if req_bus ();
   fst_rsp_if rsp_bus ();

   flow_statistics_table_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow copy of the flow table
   logic                  flow_used [FlowEntries];
   logic [NodeIdBits-1:0] flow_src [FlowEntries];
   logic [NodeIdBits-1:0] flow_dst [FlowEntries];
   logic [CountBits-1:0]  flow_attempted [FlowEntries];
   logic [CountBits-1:0]  flow_arrived [FlowEntries];
   logic [TotalBits-1:0]  flow_delay_sum [FlowEntries];

   flow_event_type  events_to_send [$];
   flow_result_type flow_results_due [$];
   logic [15:0]     known_pairs [$];

   int total_items;
   int accepted_count;
   int results_checked;
   int mismatches;
   int cycle_count;
   int status_seen [5];

   function automatic flow_result_type apply_flow_event(flow_event_type ev);
      flow_result_type       res;
      logic [NodeIdBits-1:0] s;
      logic [NodeIdBits-1:0] d;
      logic [TotalBits:0]    sum;
      int                    hit;
      int                    slot;
      s = ev.src_node[NodeIdBits-1:0];
      d = ev.dest_node[NodeIdBits-1:0];
      res.status = ST_UNKNOWN;
      res.attempted_count = '0;
      res.arrived_count = '0;
      res.delay_total = '0;
      hit = -1;
      slot = -1;
      for (int i = 0; i < FlowEntries; i++) begin
         if (hit < 0 && flow_used[i] && flow_src[i] == s && flow_dst[i] == d) hit = i;
         if (slot < 0 && !flow_used[i]) slot = i;
      end
      case (ev.action)
         ACT_ADD: begin
            if (hit >= 0) begin
               res.status = ST_PRESENT;
            end else if (slot >= 0) begin
               flow_used[slot] = 1'b1;
               flow_src[slot] = s;
               flow_dst[slot] = d;
               flow_attempted[slot] = '0;
               flow_arrived[slot] = '0;
               flow_delay_sum[slot] = '0;
               res.status = ST_ADDED;
               hit = slot;
            end else begin
               res.status = ST_FULL;
            end
         end
         ACT_CREATED: begin
            if (hit >= 0) begin
               if (flow_attempted[hit] != '1) flow_attempted[hit] = flow_attempted[hit] + 1;
               res.status = ST_UPDATED;
            end
         end
         ACT_ARRIVED: begin
            if (hit >= 0) begin
               if (flow_arrived[hit] != '1) flow_arrived[hit] = flow_arrived[hit] + 1;
               sum = {1'b0, flow_delay_sum[hit]} + ev.delay;
               flow_delay_sum[hit] = sum[TotalBits] ? '1 : sum[TotalBits-1:0];
               res.status = ST_UPDATED;
            end
         end
         default: hit = -1;
      endcase
      if (hit >= 0) begin
         res.attempted_count = flow_attempted[hit];
         res.arrived_count = flow_arrived[hit];
         res.delay_total = flow_delay_sum[hit];
      end
      return res;
   endfunction

   task automatic queue_event(input logic [ActionBits-1:0] action, input logic [7:0] s,
                              input logic [7:0] d, input logic [15:0] delay);
      flow_event_type ev;
      ev.action = action;
      ev.src_node = s;
      ev.dest_node = d;
      ev.delay = delay;
      events_to_send = {events_to_send, ev};
   endtask

   function automatic logic [15:0] pick_delay();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'hffff;
      if (r < 20) return 16'h0000;
      return 16'($urandom_range(0, 65535));
   endfunction

   // idle percentages per phase of the run
   function automatic int sender_gap_pct();
      if (accepted_count < total_items / 3) return 15;
      if (accepted_count < 2 * total_items / 3) return 67;
      return 0;
   endfunction

   function automatic int receiver_stall_pct();
      if (accepted_count < total_items / 3) return 67;
      if (accepted_count < 2 * total_items / 3) return 15;
      return 0;
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d of %0d items accepted",
                  cycle_count, accepted_count, total_items);
         $display("flow_statistics_table_unit_tb failed");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            flow_results_due = {flow_results_due,
                                apply_flow_event({req_bus.action, req_bus.src_node,
                                                  req_bus.dest_node, req_bus.delay})};
            accepted_count <= accepted_count + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (events_to_send.size() > 0 && $urandom_range(0, 99) >= sender_gap_pct()) begin
               req_bus.action <= events_to_send[0].action;
               req_bus.src_node <= events_to_send[0].src_node;
               req_bus.dest_node <= events_to_send[0].dest_node;
               req_bus.delay <= events_to_send[0].delay;
               req_bus.valid <= 1'b1;
               void'(events_to_send.pop_front());
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked <= results_checked + 1;
            if (rsp_bus.status < 5) status_seen[rsp_bus.status]++;
            if (flow_results_due.size() == 0) begin
               $error("result with no pending item: status %0d", rsp_bus.status);
               mismatches++;
            end else begin
               if (rsp_bus.status !== flow_results_due[0].status) begin
                  $error("status: expected %0d, got %0d",
                         flow_results_due[0].status, rsp_bus.status);
                  mismatches++;
               end
               if (rsp_bus.attempted_count !== flow_results_due[0].attempted_count) begin
                  $error("attempted_count: expected %0d, got %0d",
                         flow_results_due[0].attempted_count, rsp_bus.attempted_count);
                  mismatches++;
               end
               if (rsp_bus.arrived_count !== flow_results_due[0].arrived_count) begin
                  $error("arrived_count: expected %0d, got %0d",
                         flow_results_due[0].arrived_count, rsp_bus.arrived_count);
                  mismatches++;
               end
               if (rsp_bus.delay_total !== flow_results_due[0].delay_total) begin
                  $error("delay_total: expected %0d, got %0d",
                         flow_results_due[0].delay_total, rsp_bus.delay_total);
                  mismatches++;
               end
               void'(flow_results_due.pop_front());
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
      end
   end

   initial begin
      int          r;
      logic [15:0] pair;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = '0;
      req_bus.src_node = '0;
      req_bus.dest_node = '0;
      req_bus.delay = '0;
      rsp_bus.ready = 1'b0;
      total_items = 0;
      accepted_count = 0;
      results_checked = 0;
      mismatches = 0;
      cycle_count = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      for (int i = 0; i < FlowEntries; i++) begin
         flow_used[i] = 1'b0;
         flow_src[i] = '0;
         flow_dst[i] = '0;
         flow_attempted[i] = '0;
         flow_arrived[i] = '0;
         flow_delay_sum[i] = '0;
      end

      // directed: empty table, extreme node ids, duplicate adds, extreme delays
      queue_event(ACT_CREATED, 8'h00, 8'h00, 16'h0000);
      queue_event(ACT_ADD, 8'h00, 8'h00, 16'hffff);
      queue_event(ACT_ADD, 8'h00, 8'h00, 16'h0000);
      queue_event(ACT_ADD, 8'hff, 8'hff, 16'h0000);
      queue_event(ACT_ADD, 8'h00, 8'hff, 16'h0000);
      queue_event(ACT_ADD, 8'hff, 8'h00, 16'h0000);
      queue_event(ACT_CREATED, 8'h00, 8'h00, 16'h1234);
      queue_event(ACT_CREATED, 8'h00, 8'h00, 16'h0000);
      queue_event(ACT_ARRIVED, 8'h00, 8'h00, 16'hffff);
      queue_event(ACT_ARRIVED, 8'h00, 8'h00, 16'h0000);
      queue_event(ACT_ARRIVED, 8'hff, 8'hff, 16'hffff);
      queue_event(ACT_ARRIVED, 8'hff, 8'hff, 16'hffff);
      queue_event(ACT_CREATED, 8'h00, 8'hff, 16'h0000);
      queue_event(ACT_UNUSED, 8'h00, 8'h00, 16'hffff);
      queue_event(ACT_ARRIVED, 8'h00, 8'h01, 16'h0040);
      queue_event(ACT_CREATED, 8'hff, 8'hfe, 16'h0000);
      queue_event(ACT_ADD, 8'h00, 8'h00, 16'h0000);
      queue_event(ACT_ADD, 8'h55, 8'haa, 16'h0000);
      queue_event(ACT_ADD, 8'haa, 8'h55, 16'h0000);
      queue_event(ACT_ARRIVED, 8'h55, 8'haa, 16'h8001);
      queue_event(ACT_ARRIVED, 8'haa, 8'h55, 16'h7ffe);
      known_pairs = '{16'h0000, 16'hffff, 16'h00ff, 16'hff00, 16'h55aa, 16'haa55};

      // random: mostly traffic on known flows, plus new adds that go on past a full table
      for (int n = 0; n < RandomEvents; n++) begin
         r = $urandom_range(0, 99);
         pair = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
         if (r < 10) begin
            pair = 16'($urandom_range(0, 65535));
            if (known_pairs.size() < PoolLimit) known_pairs = {known_pairs, pair};
            queue_event(ACT_ADD, pair[15:8], pair[7:0], pick_delay());
         end else if (r < 15) begin
            queue_event(ACT_ADD, pair[15:8], pair[7:0], pick_delay());
         end else if (r < 50) begin
            queue_event(ACT_CREATED, pair[15:8], pair[7:0], pick_delay());
         end else if (r < 85) begin
            queue_event(ACT_ARRIVED, pair[15:8], pair[7:0], pick_delay());
         end else if (r < 93) begin
            pair = 16'($urandom_range(0, 65535));
            queue_event(r[0] ? ACT_CREATED : ACT_ARRIVED, pair[15:8], pair[7:0], pick_delay());
         end else begin
            queue_event(ACT_UNUSED, pair[15:8], pair[7:0], pick_delay());
         end
      end
      total_items = events_to_send.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items) @(posedge clock);
      while (flow_results_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("%0d events sent, %0d results checked, %0d field mismatches",
               total_items, results_checked, mismatches);
      $display("status mix: updated %0d, unknown %0d, added %0d, present %0d, full %0d",
               status_seen[ST_UPDATED], status_seen[ST_UNKNOWN], status_seen[ST_ADDED],
               status_seen[ST_PRESENT], status_seen[ST_FULL]);
      if (mismatches == 0 && results_checked == total_items) begin
         $display("flow_statistics_table_unit_tb passed");
      end else begin
         $display("flow_statistics_table_unit_tb failed");
      end
      $finish;
   end

endmodule
